FILE: rtl/core/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg: shared constants and types of the segment pair intersection block
// widths of the item buses, stage counts and the flag group that rides along
// ----------------------------------------------------------------------------
package sgi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IN_W       = 16;
  localparam int N_IN       = 8;
  localparam int IN_DATA_W  = IN_W * N_IN;
  localparam int OUT_W      = 32;
  localparam int OUT_DATA_W = 72;

  // quotient bits kept by the divider, one above the output width
  localparam int QB = OUT_W + 1;

  localparam int FRONT_STG = 3;
  localparam int NUMER_STG = 4;
  localparam int DIV_STG   = QB + 3;
  localparam int PIPE_STG  = FRONT_STG + NUMER_STG + DIV_STG;
  localparam int SIDE_STG  = NUMER_STG + DIV_STG;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic hit;
    logic par;
  } flags_t;

endpackage

FILE: rtl/core/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front: orientation test and line determinants
// three stages: coordinate differences, products, sums with the hit decision
// ----------------------------------------------------------------------------
module sgi_front #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [sgi_pkg::IN_DATA_W-1:0]      in_data,
  output logic signed [COORD_BITS-1:0]       x1_o,
  output logic signed [COORD_BITS-1:0]       y1_o,
  output logic signed [COORD_BITS:0]         d21x_o,
  output logic signed [COORD_BITS:0]         d21y_o,
  output logic signed [2*COORD_BITS+2:0]     den_o,
  output logic signed [2*COORD_BITS+2:0]     num_o,
  output sgi_pkg::flags_t                    flags_o
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int DENW = PW + 1;
  localparam int EXW  = (CB > sgi_pkg::IN_W) ? CB : sgi_pkg::IN_W;

  typedef enum logic [1:0] {ORI_ZERO, ORI_POS, ORI_NEG} ori_t;

  function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic between(input logic signed [CB-1:0] a,
                                   input logic signed [CB-1:0] b,
                                   input logic signed [CB-1:0] q);
    return (q >= a && q <= b) || (q >= b && q <= a);
  endfunction

  function automatic ori_t ori(input logic signed [PW-1:0] a,
                               input logic signed [PW-1:0] b);
    logic signed [DENW-1:0] v;
    v = DENW'(a) - DENW'(b);
    if (v == '0) begin
      return ORI_ZERO;
    end else if (v[DENW-1]) begin
      return ORI_NEG;
    end else begin
      return ORI_POS;
    end
  endfunction

  // x1 y1 x2 y2 x3 y3 x4 y4
  logic signed [CB-1:0] c [sgi_pkg::N_IN];

  for (genvar i = 0; i < sgi_pkg::N_IN; i++) begin : g_in
    logic [EXW-1:0] raw_ext;
    assign raw_ext = EXW'(in_data[i*sgi_pkg::IN_W +: sgi_pkg::IN_W]);
    assign c[i]    = $signed(raw_ext[CB-1:0]);
  end

  // stage 1
  logic signed [CB-1:0] s1_c_r [sgi_pkg::N_IN];
  logic signed [DW-1:0] d21x_r, d21y_r, d32x_r, d32y_r, d42x_r, d42y_r;
  logic signed [DW-1:0] d43x_r, d43y_r, d14x_r, d14y_r, d24x_r, d24y_r;
  logic signed [DW-1:0] d31x_r, d31y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < sgi_pkg::N_IN; i++) begin
        s1_c_r[i] <= c[i];
      end
      d21x_r <= sub(c[2], c[0]);
      d21y_r <= sub(c[3], c[1]);
      d32x_r <= sub(c[4], c[2]);
      d32y_r <= sub(c[5], c[3]);
      d42x_r <= sub(c[6], c[2]);
      d42y_r <= sub(c[7], c[3]);
      d43x_r <= sub(c[6], c[4]);
      d43y_r <= sub(c[7], c[5]);
      d14x_r <= sub(c[0], c[6]);
      d14y_r <= sub(c[1], c[7]);
      d24x_r <= sub(c[2], c[6]);
      d24y_r <= sub(c[3], c[7]);
      d31x_r <= sub(c[4], c[0]);
      d31y_r <= sub(c[5], c[1]);
    end
  end

  // stage 2: products, on-segment range checks
  logic signed [PW-1:0] p_r [12];
  logic [3:0]           w_r;
  logic signed [CB-1:0] s2_x1_r, s2_y1_r;
  logic signed [DW-1:0] s2_d21x_r, s2_d21y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= mul(d21x_r, d43y_r);
      p_r[1]  <= mul(d21y_r, d43x_r);
      p_r[2]  <= mul(d31x_r, d43y_r);
      p_r[3]  <= mul(d31y_r, d43x_r);
      p_r[4]  <= mul(d21y_r, d32x_r);
      p_r[5]  <= mul(d21x_r, d32y_r);
      p_r[6]  <= mul(d21y_r, d42x_r);
      p_r[7]  <= mul(d21x_r, d42y_r);
      p_r[8]  <= mul(d43y_r, d14x_r);
      p_r[9]  <= mul(d43x_r, d14y_r);
      p_r[10] <= mul(d43y_r, d24x_r);
      p_r[11] <= mul(d43x_r, d24y_r);
      w_r[0]  <= between(s1_c_r[0], s1_c_r[2], s1_c_r[4]) &&
                 between(s1_c_r[1], s1_c_r[3], s1_c_r[5]);
      w_r[1]  <= between(s1_c_r[0], s1_c_r[2], s1_c_r[6]) &&
                 between(s1_c_r[1], s1_c_r[3], s1_c_r[7]);
      w_r[2]  <= between(s1_c_r[4], s1_c_r[6], s1_c_r[0]) &&
                 between(s1_c_r[5], s1_c_r[7], s1_c_r[1]);
      w_r[3]  <= between(s1_c_r[4], s1_c_r[6], s1_c_r[2]) &&
                 between(s1_c_r[5], s1_c_r[7], s1_c_r[3]);
      s2_x1_r   <= s1_c_r[0];
      s2_y1_r   <= s1_c_r[1];
      s2_d21x_r <= d21x_r;
      s2_d21y_r <= d21y_r;
    end
  end

  // stage 3: determinants and the hit decision
  ori_t o1, o2, o3, o4;
  logic hit;

  always_comb begin
    o1  = ori(p_r[4], p_r[5]);
    o2  = ori(p_r[6], p_r[7]);
    o3  = ori(p_r[8], p_r[9]);
    o4  = ori(p_r[10], p_r[11]);
    hit = (o1 != o2 && o3 != o4) ||
          (o1 == ORI_ZERO && w_r[0]) || (o2 == ORI_ZERO && w_r[1]) ||
          (o3 == ORI_ZERO && w_r[2]) || (o4 == ORI_ZERO && w_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o         <= DENW'(p_r[0]) - DENW'(p_r[1]);
      num_o         <= DENW'(p_r[2]) - DENW'(p_r[3]);
      flags_o.hit   <= hit;
      flags_o.par   <= (p_r[0] == p_r[1]);
      x1_o          <= s2_x1_r;
      y1_o          <= s2_y1_r;
      d21x_o        <= s2_d21x_r;
      d21y_o        <= s2_d21y_r;
    end
  end

endmodule

FILE: rtl/core/sgi_numer.sv
// ----------------------------------------------------------------------------
// sgi_numer: crossing numerator for one axis, c*den + dc*num
// split partial products, combine, add, then sign and magnitude
// ----------------------------------------------------------------------------
module sgi_numer #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_BITS-1:0]      c_i,
  input  logic signed [COORD_BITS:0]        dc_i,
  input  logic signed [2*COORD_BITS+2:0]    den_i,
  input  logic signed [2*COORD_BITS+2:0]    num_i,
  output logic [3*COORD_BITS+4:0]           mag_o,
  output logic                              neg_o,
  output logic [2*COORD_BITS+2:0]           dmag_o
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int DENW = 2 * CB + 3;
  localparam int NXW  = 3 * CB + 5;
  localparam int SPL  = DENW / 2;
  localparam int HW   = DENW - SPL;
  localparam int AHW  = CB + HW;
  localparam int ALW  = CB + SPL + 1;
  localparam int BHW  = DW + HW;
  localparam int BLW  = DW + SPL + 1;

  // stage 1: partial products on split den and num
  logic signed [AHW-1:0]  pa_hi_r;
  logic signed [ALW-1:0]  pa_lo_r;
  logic signed [BHW-1:0]  pb_hi_r;
  logic signed [BLW-1:0]  pb_lo_r;
  logic signed [DENW-1:0] den1_r, den2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_hi_r <= AHW'(c_i) * AHW'($signed(den_i[DENW-1:SPL]));
      pa_lo_r <= ALW'(c_i) * ALW'($signed({1'b0, den_i[SPL-1:0]}));
      pb_hi_r <= BHW'(dc_i) * BHW'($signed(num_i[DENW-1:SPL]));
      pb_lo_r <= BLW'(dc_i) * BLW'($signed({1'b0, num_i[SPL-1:0]}));
      den1_r  <= den_i;
    end
  end

  // stage 2: rebuild the two products
  logic signed [NXW-1:0] pa_r, pb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= (NXW'(pa_hi_r) <<< SPL) + NXW'(pa_lo_r);
      pb_r   <= (NXW'(pb_hi_r) <<< SPL) + NXW'(pb_lo_r);
      den2_r <= den1_r;
    end
  end

  // stage 3: numerator sum
  logic signed [NXW-1:0] nsum_r;
  logic                  dneg_r;
  logic [DENW-1:0]       dmag3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nsum_r  <= pa_r + pb_r;
      dneg_r  <= den2_r[DENW-1];
      dmag3_r <= den2_r[DENW-1] ? DENW'(-den2_r) : DENW'(den2_r);
    end
  end

  // stage 4: magnitude and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      mag_o  <= nsum_r[NXW-1] ? NXW'(-nsum_r) : NXW'(nsum_r);
      neg_o  <= nsum_r[NXW-1] ^ dneg_r;
      dmag_o <= dmag3_r;
    end
  end

endmodule

FILE: rtl/core/sgi_divider.sv
// ----------------------------------------------------------------------------
// sgi_divider: pipelined restoring divider, one quotient bit per step stage
// overflow check up front, round to nearest, saturate to the output range
// ----------------------------------------------------------------------------
module sgi_divider #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [3*COORD_BITS+4:0]           mag_i,
  input  logic                              neg_i,
  input  logic [2*COORD_BITS+2:0]           dmag_i,
  output logic [sgi_pkg::OUT_W-1:0]         value_o,
  output logic                              sat_o
);

  localparam int QB   = sgi_pkg::QB;
  localparam int OW   = sgi_pkg::OUT_W;
  localparam int DENW = 2 * COORD_BITS + 3;
  localparam int NXW  = 3 * COORD_BITS + 5;
  localparam int TW   = NXW + FRAC_BITS;
  localparam int EW   = TW + QB;

  logic [EW-1:0] ext;
  logic [TW-1:0] top;

  assign ext = EW'(mag_i) << FRAC_BITS;
  assign top = ext[EW-1:QB];

  logic [DENW-1:0] rem_r  [QB+1];
  logic [DENW-1:0] dm_r   [QB+1];
  logic [QB-1:0]   low_r  [QB];
  logic [QB-1:0]   q_r    [QB+1];
  logic            neg_r  [QB+1];
  logic            ovf_r  [QB+1];

  // stage 0: quotient above the kept bits means overflow
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= top >= TW'(dmag_i);
      rem_r[0] <= top[DENW-1:0];
      low_r[0] <= ext[QB-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
      dm_r[0]  <= dmag_i;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DENW:0] trial;
    logic          ge;
    logic [DENW:0] diff;

    assign trial = {rem_r[k-1], low_r[k-1][QB-1]};
    assign ge    = trial >= {1'b0, dm_r[k-1]};
    assign diff  = trial - {1'b0, dm_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        dm_r[k]  <= dm_r[k-1];
      end
    end

    // the last step has no dividend bits left to shift on
    if (k < QB) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[k] <= low_r[k-1] << 1;
        end
      end
    end
  end

  // round half away from zero on the magnitude
  logic [QB:0] qr_r;
  logic        rneg_r, rovf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r   <= (QB+1)'(q_r[QB]) +
                (QB+1)'({rem_r[QB], 1'b0} >= {1'b0, dm_r[QB]});
      rneg_r <= neg_r[QB];
      rovf_r <= ovf_r[QB];
    end
  end

  logic pos_big, neg_big;
  assign pos_big = rovf_r || qr_r > (QB+1)'(sgi_pkg::OUT_MAX);
  assign neg_big = rovf_r || qr_r > (QB+1)'(sgi_pkg::OUT_MIN);

  always_ff @(posedge clk) begin
    if (en) begin
      if (rneg_r) begin
        sat_o   <= neg_big;
        value_o <= neg_big ? sgi_pkg::OUT_MIN : OW'(-qr_r[OW-1:0]);
      end else begin
        sat_o   <= pos_big;
        value_o <= pos_big ? sgi_pkg::OUT_MAX : qr_r[OW-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/segment_pair_intersection.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection: closed segment meet test and line crossing point
// in_* carries two segments as eight signed coordinates, out_* gives the
// intersects and parallel flags and the crossing point in signed fixed point
//
// one item enters per cycle while in_tready is high; every item leaves on the output
// register (3 front stages, 4 numerator stages, 36 divider stages, 1 output)
// the depth is set by the quotient bits, one bit per divider step stage
// the whole pipeline advances when the output register is empty or taken;
// while out_tready is low with an item waiting, in_tready drops and every
// stage holds its item, so nothing is lost or repeated
// after rst_n all valid bits are clear; no other pipeline register is reset
// when the lines are parallel the point and the saturation flag read zero
// ----------------------------------------------------------------------------
module segment_pair_intersection #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // a_upper_x, a_upper_y, a_lower_x, a_lower_y,
  // b_upper_x, b_upper_y, b_lower_x, b_lower_y, 16 bits each
  input  logic [sgi_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // intersects, parallel, cross_x[31:0], cross_y[31:0], saturated, zero pad
  output logic [sgi_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CB   = COORD_BITS;
  localparam int DENW = 2 * CB + 3;
  localparam int NXW  = 3 * CB + 5;
  localparam int OW   = sgi_pkg::OUT_W;
  localparam int PIPE = sgi_pkg::PIPE_STG;
  localparam int SIDE = sgi_pkg::SIDE_STG;

  logic [PIPE-1:0] vld_r;
  logic            out_tvalid_r;

  logic advance, accept;
  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && in_tready;

  logic signed [CB-1:0]   x1, y1;
  logic signed [CB:0]     d21x, d21y;
  logic signed [DENW-1:0] den, num;
  sgi_pkg::flags_t        flags;

  sgi_front #(.COORD_BITS(CB)) u_front (
    .clk     (clk),
    .en      (advance),
    .in_data (in_tdata),
    .x1_o    (x1),
    .y1_o    (y1),
    .d21x_o  (d21x),
    .d21y_o  (d21y),
    .den_o   (den),
    .num_o   (num),
    .flags_o (flags)
  );

  logic [NXW-1:0]  mag_x, mag_y;
  logic            neg_x, neg_y;
  logic [DENW-1:0] dmag_x, dmag_y;

  sgi_numer #(.COORD_BITS(CB)) u_numer_x (
    .clk    (clk),
    .en     (advance),
    .c_i    (x1),
    .dc_i   (d21x),
    .den_i  (den),
    .num_i  (num),
    .mag_o  (mag_x),
    .neg_o  (neg_x),
    .dmag_o (dmag_x)
  );

  sgi_numer #(.COORD_BITS(CB)) u_numer_y (
    .clk    (clk),
    .en     (advance),
    .c_i    (y1),
    .dc_i   (d21y),
    .den_i  (den),
    .num_i  (num),
    .mag_o  (mag_y),
    .neg_o  (neg_y),
    .dmag_o (dmag_y)
  );

  logic [OW-1:0] val_x, val_y;
  logic          sat_x, sat_y;

  sgi_divider #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk     (clk),
    .en      (advance),
    .mag_i   (mag_x),
    .neg_i   (neg_x),
    .dmag_i  (dmag_x),
    .value_o (val_x),
    .sat_o   (sat_x)
  );

  sgi_divider #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk     (clk),
    .en      (advance),
    .mag_i   (mag_y),
    .neg_i   (neg_y),
    .dmag_i  (dmag_y),
    .value_o (val_y),
    .sat_o   (sat_y)
  );

  // flags ride beside the numerator and divider stages
  sgi_pkg::flags_t flag_r [SIDE];

  always_ff @(posedge clk) begin
    if (advance) begin
      flag_r[0] <= flags;
      for (int k = 1; k < SIDE; k++) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
  end

  logic          o_hit_r, o_par_r, o_sat_r;
  logic [OW-1:0] o_cx_r, o_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      vld_r        <= {vld_r[PIPE-2:0], accept};
      out_tvalid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_hit_r <= flag_r[SIDE-1].hit;
      o_par_r <= flag_r[SIDE-1].par;
      o_cx_r  <= flag_r[SIDE-1].par ? '0 : val_x;
      o_cy_r  <= flag_r[SIDE-1].par ? '0 : val_y;
      o_sat_r <= !flag_r[SIDE-1].par && (sat_x || sat_y);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, o_sat_r, o_cy_r, o_cx_r, o_par_r, o_hit_r};

`ifndef SYNTH
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && o_par_r |-> o_cx_r == '0 && o_cy_r == '0 && !o_sat_r)
    else $error("parallel item carries a crossing point");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && o_sat_r |->
      o_cx_r == sgi_pkg::OUT_MAX || o_cx_r == sgi_pkg::OUT_MIN ||
      o_cy_r == sgi_pkg::OUT_MAX || o_cy_r == sgi_pkg::OUT_MIN)
    else $error("saturated item without a clipped coordinate");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: sim/segment_pair_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection_test: self-checking bench for the segment meet test
// drives segment pairs on the input stream, predicts the meet flag, parallel
// flag and Q16.16 crossing point of each accepted item, and compares results
// in order, with random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module segment_pair_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = sgi_pkg::FRAC_BITS_DEF;
  localparam int HOLD_LEN  = 300;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 60;

  typedef logic signed [15:0] coord_t;
  typedef coord_t seg_pair_t [8];

  typedef struct {
    logic         hit;
    logic         par;
    logic [31:0]  cx;
    logic [31:0]  cy;
    logic         sat;
  } meet_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [sgi_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [sgi_pkg::OUT_DATA_W-1:0] out_tdata;

  meet_t meet_q[$];
  int    n_err;
  bit    quiet;
  bit    hold_req;
  int    hold_cnt;
  int    wdog;

  segment_pair_intersection uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int orient_of(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return 0;
    return (v > 0) ? 1 : 2;
  endfunction

  function automatic bit on_box(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    return qx >= ((px < rx) ? px : rx) && qx <= ((px < rx) ? rx : px) &&
           qy >= ((py < ry) ? py : ry) && qy <= ((py < ry) ? ry : py);
  endfunction

  // rounded n * 2^FRAC / d, ties away from zero, clipped to 32 bits
  function automatic logic [32:0] fixed_quot(logic signed [127:0] n,
                                             logic signed [127:0] d);
    logic        neg;
    logic [127:0] un, ud, q, r;
    neg = (n < 0) ^ (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    un  = un << FRAC;
    q   = un / ud;
    r   = un % ud;
    if (r >= ud - r) q = q + 1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) return {1'b1, sgi_pkg::OUT_MAX};
      return {1'b0, q[31:0]};
    end
    if (q > 128'h8000_0000) return {1'b1, sgi_pkg::OUT_MIN};
    return {1'b0, 32'(-q[31:0])};
  endfunction

  function automatic meet_t predict_meet(logic [sgi_pkg::IN_DATA_W-1:0] d);
    longint x1, y1, x2, y2, x3, y3, x4, y4, den, num;
    int o1, o2, o3, o4;
    logic signed [127:0] nx, ny;
    logic [32:0] fx, fy;
    meet_t m;
    x1 = $signed(d[15:0]);    y1 = $signed(d[31:16]);
    x2 = $signed(d[47:32]);   y2 = $signed(d[63:48]);
    x3 = $signed(d[79:64]);   y3 = $signed(d[95:80]);
    x4 = $signed(d[111:96]);  y4 = $signed(d[127:112]);
    o1 = orient_of(x1, y1, x2, y2, x3, y3);
    o2 = orient_of(x1, y1, x2, y2, x4, y4);
    o3 = orient_of(x3, y3, x4, y4, x1, y1);
    o4 = orient_of(x3, y3, x4, y4, x2, y2);
    m.hit = (o1 != o2 && o3 != o4) ||
            (o1 == 0 && on_box(x1, y1, x3, y3, x2, y2)) ||
            (o2 == 0 && on_box(x1, y1, x4, y4, x2, y2)) ||
            (o3 == 0 && on_box(x3, y3, x1, y1, x4, y4)) ||
            (o4 == 0 && on_box(x3, y3, x2, y2, x4, y4));
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    m.par = (den == 0);
    m.cx = '0;
    m.cy = '0;
    m.sat = 1'b0;
    if (den != 0) begin
      num = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
      nx = 128'(x1) * 128'(den) + 128'(x2 - x1) * 128'(num);
      ny = 128'(y1) * 128'(den) + 128'(y2 - y1) * 128'(num);
      fx = fixed_quot(nx, 128'(den));
      fy = fixed_quot(ny, 128'(den));
      m.cx = fx[31:0];
      m.cy = fy[31:0];
      m.sat = fx[32] | fy[32];
    end
    return m;
  endfunction

  // expectation is formed from what the block actually took
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) meet_q.push_back(predict_meet(in_tdata));
  end

  always @(posedge clk) begin
    meet_t e;
    logic [31:0] gx, gy;
    if (rst_n && out_tvalid && out_tready) begin
      if (meet_q.size() == 0) begin
        $display("%0t: result with no item pending, got %h", $realtime, out_tdata);
        n_err++;
      end else begin
        e  = meet_q.pop_front();
        gx = out_tdata[33:2];
        gy = out_tdata[65:34];
        if (out_tdata[0] !== e.hit) begin
          $display("%0t: intersects exp %b got %b", $realtime, e.hit, out_tdata[0]);
          n_err++;
        end
        if (out_tdata[1] !== e.par) begin
          $display("%0t: parallel exp %b got %b", $realtime, e.par, out_tdata[1]);
          n_err++;
        end
        if (gx !== e.cx) begin
          $display("%0t: cross_x exp %h got %h", $realtime, e.cx, gx);
          n_err++;
        end
        if (gy !== e.cy) begin
          $display("%0t: cross_y exp %h got %h", $realtime, e.cy, gy);
          n_err++;
        end
        if (out_tdata[66] !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $realtime, e.sat, out_tdata[66]);
          n_err++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_cnt   <= HOLD_LEN;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic send_pair(seg_pair_t c);
    if (!quiet && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send8(int ax1, int ay1, int ax2, int ay2,
                       int bx1, int by1, int bx2, int by2);
    seg_pair_t c;
    c = '{coord_t'(ax1), coord_t'(ay1), coord_t'(ax2), coord_t'(ay2),
          coord_t'(bx1), coord_t'(by1), coord_t'(bx2), coord_t'(by2)};
    send_pair(c);
  endtask

  function automatic seg_pair_t random_pair();
    seg_pair_t c;
    int span, k, dx, dy;
    k = $urandom_range(9);
    span = (k < 3) ? 32767 : (k < 7) ? 40 : 8;
    foreach (c[i]) c[i] = coord_t'($urandom_range(2 * span) - span);
    if (k == 9) begin
      // parallel or near-parallel lines so any crossing lands far away
      dx = $urandom_range(32767);
      dy = $urandom_range(3);
      c[2] = c[0] + coord_t'(dx);
      c[3] = c[1] + coord_t'(dy);
      c[6] = c[4] + coord_t'(dx - $urandom_range(1));
      c[7] = c[5] + coord_t'(dy);
    end else if (k == 8) begin
      // b's first point takes its x and its y from end points of a, the same or different ones
      c[4] = c[$urandom_range(1) * 2];
      c[5] = c[$urandom_range(1) * 2 + 1];
    end
    return c;
  endfunction

  task automatic test_directed();
    send8(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send8(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send8(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send8(0, 0, 4, 4, 0, 4, 4, 0);          // plain crossing
    send8(0, 0, 4, 0, 0, 1, 4, 1);          // parallel, apart
    send8(0, 0, 4, 0, 2, 0, 8, 0);          // collinear overlap
    send8(0, 0, 4, 0, 5, 0, 8, 0);          // collinear, apart
    send8(0, 0, 4, 4, 4, 4, 8, 0);          // touching at an end point
    send8(0, 0, 4, 4, 2, 2, 2, 2);          // b is a point on a
    send8(0, 0, 4, 4, 3, 1, 3, 1);          // b is a point off a
    send8(5, 5, 5, 5, 5, 5, 5, 5);          // both points, same place
    send8(2, -5, 2, 5, -3, 0, 7, 0);        // vertical against horizontal
    send8(2, -5, 2, 5, 3, -5, 3, 5);        // two verticals
    send8(0, 0, 4, 4, 0, 1, 4, 6);          // lines cross outside segments
    send8(0, 0, 3, 1, 0, 1, 3, 0);          // crossing point at (1.5, 0.5)
    send8(0, 0, 32767, 1, 0, 1, 32766, 2);  // crossing far left, clipped
    send8(0, 0, -32768, 1, 0, 1, -32767, 2);
    send8(0, 0, 32767, -1, 0, -1, 32766, -2);
    send8(-1, -1, 1, 1, -1, 1, 1, -1);      // point at origin
    send8(-32768, 0, 32767, 1, -32768, 1, 32767, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(random_pair());
  endtask

  task automatic test_no_idle(int n);
    quiet = 1'b1;
    test_random(n);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    test_random(120);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    n_err     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_no_idle(300);
    test_random(600);
    in_tvalid <= 1'b0;
    while (meet_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sgi_pkg.sv
rtl/core/sgi_front.sv
rtl/core/sgi_numer.sv
rtl/core/sgi_divider.sv
rtl/core/segment_pair_intersection.sv
sim/segment_pair_intersection_test.sv
